FILE: rtl/cse_pkg.sv
// Shared constants, codes and types for the counting semaphore engine.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package cse_pkg;

  localparam int NUM_SEMS    = 16;
  localparam int SEM_BITS    = $clog2(NUM_SEMS);
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QLEN_BITS   = QPTR_BITS + 1;
  localparam int PID_BITS    = 5;
  localparam int COUNT_BITS  = 8;
  localparam int SLOT_BITS   = SEM_BITS + QPTR_BITS;
  localparam int SLOT_DEPTH  = NUM_SEMS * QUEUE_DEPTH;

  localparam int OP_W     = 2;
  localparam int SIDX_W   = 4;
  localparam int INIT_W   = 8;
  localparam int PID_W    = 5;
  localparam int STATUS_W = 3;
  localparam int ERR_W    = 2;
  localparam int CNT_W    = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [QLEN_BITS-1:0]  QLEN_FULL = QLEN_BITS'(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_WAIT  = 2'd1,
    OP_POST  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED   = 3'd0,
    ST_PASSED      = 3'd1,
    ST_BLOCKED     = 3'd2,
    ST_WOKE        = 3'd3,
    ST_INCREMENTED = 3'd4,
    ST_ERROR       = 3'd5
  } status_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_FREE    = 2'd1,
    ERR_QUEUE_FULL = 2'd2
  } err_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic latch;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic req_nop;
  } stat_t;

endpackage

FILE: rtl/counting_semaphore_engine.sv
// Counting semaphore engine: a table of semaphores with FIFO wait queues.
// Top level; instantiates cse_ctrl and cse_dpath, depends on cse_pkg.
//
// Usage:
//   Request channel (req_valid/req_ready) carries op, sem_index,
//   initial_count and caller_pid. Response channel (rsp_valid/rsp_ready)
//   carries status, error_kind, sem_index_out, woken_pid and count_now.
//   Allocate, wait and post each give one response; op code 3 is accepted
//   and dropped with no response.
//   Each request is executed before the next is taken, as set by the
//   read-modify-write of the addressed table entry and the registered
//   read of the waiter slot memory (read on accept, updated on execute).
//   A new request is taken while an earlier response still waits; if the
//   receiver stalls, execution holds until the response register frees.
//   Reset: synchronous, active high; clears owners, pass counts, queue heads
//   and lengths. Waiter slots are not cleared.
module counting_semaphore_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [cse_pkg::OP_W-1:0]      op,
  input  logic [cse_pkg::SIDX_W-1:0]    sem_index,
  input  logic [cse_pkg::INIT_W-1:0]    initial_count,
  input  logic [cse_pkg::PID_W-1:0]     caller_pid,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [cse_pkg::STATUS_W-1:0]  status,
  output logic [cse_pkg::ERR_W-1:0]     error_kind,
  output logic [cse_pkg::SIDX_W-1:0]    sem_index_out,
  output logic [cse_pkg::PID_W-1:0]     woken_pid,
  output logic [cse_pkg::CNT_W-1:0]     count_now
);

  cse_pkg::cmd_t  cmd;
  cse_pkg::stat_t stat;

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cse_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .sem_index     (sem_index),
    .initial_count (initial_count),
    .caller_pid    (caller_pid),
    .status        (status),
    .error_kind    (error_kind),
    .sem_index_out (sem_index_out),
    .woken_pid     (woken_pid),
    .count_now     (count_now)
  );

endmodule

FILE: rtl/cse_ctrl.sv
// Controller for the counting semaphore engine: request/execute sequencing
// and the response valid flag. Depends on cse_pkg.
module cse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  cse_pkg::stat_t stat,
  output cse_pkg::cmd_t  cmd
);

  cse_pkg::state_t state, state_next;
  logic            rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cse_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd            = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      cse_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch = 1'b1;
          if (!stat.req_nop) state_next = cse_pkg::S_EXEC;
        end
      end
      cse_pkg::S_EXEC: begin
        // hold until the response register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = cse_pkg::S_IDLE;
        end
      end
      default: state_next = cse_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/cse_dpath.sv
// Datapath for the counting semaphore engine: semaphore tables, waiter
// slot memory, request latch and response register. Depends on cse_pkg.
module cse_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  cse_pkg::cmd_t                 cmd,
  output cse_pkg::stat_t                stat,
  input  logic [cse_pkg::OP_W-1:0]      op,
  input  logic [cse_pkg::SIDX_W-1:0]    sem_index,
  input  logic [cse_pkg::INIT_W-1:0]    initial_count,
  input  logic [cse_pkg::PID_W-1:0]     caller_pid,
  output logic [cse_pkg::STATUS_W-1:0]  status,
  output logic [cse_pkg::ERR_W-1:0]     error_kind,
  output logic [cse_pkg::SIDX_W-1:0]    sem_index_out,
  output logic [cse_pkg::PID_W-1:0]     woken_pid,
  output logic [cse_pkg::CNT_W-1:0]     count_now
);

  logic [cse_pkg::PID_BITS-1:0]   owner_ids     [cse_pkg::NUM_SEMS];
  logic [cse_pkg::COUNT_BITS-1:0] pass_counts   [cse_pkg::NUM_SEMS];
  logic [cse_pkg::QPTR_BITS-1:0]  queue_heads   [cse_pkg::NUM_SEMS];
  logic [cse_pkg::QLEN_BITS-1:0]  queue_lengths [cse_pkg::NUM_SEMS];
  logic [cse_pkg::PID_BITS-1:0]   waiter_slots  [cse_pkg::SLOT_DEPTH];

  cse_pkg::op_t                   req_op;
  logic [cse_pkg::SEM_BITS-1:0]   req_sem;
  logic [cse_pkg::COUNT_BITS-1:0] req_init;
  logic [cse_pkg::PID_BITS-1:0]   req_pid;
  logic [cse_pkg::PID_BITS-1:0]   slot_rdata;

  logic [cse_pkg::SEM_BITS-1:0]   in_sem;
  logic [cse_pkg::SLOT_BITS-1:0]  slot_raddr;
  logic [cse_pkg::SLOT_BITS-1:0]  slot_waddr;
  logic                           slot_we;

  logic                           free_found;
  logic [cse_pkg::SEM_BITS-1:0]   free_idx;

  logic [cse_pkg::SEM_BITS-1:0]   tgt;
  logic [cse_pkg::COUNT_BITS-1:0] cnt;
  logic [cse_pkg::QPTR_BITS-1:0]  head;
  logic [cse_pkg::QLEN_BITS-1:0]  len;
  logic [cse_pkg::QPTR_BITS-1:0]  tail;
  logic                           tbl_we;
  logic                           owner_we;
  logic [cse_pkg::COUNT_BITS-1:0] cnt_next;
  logic [cse_pkg::QPTR_BITS-1:0]  head_next;
  logic [cse_pkg::QLEN_BITS-1:0]  len_next;

  cse_pkg::status_t               st_next;
  cse_pkg::err_t                  err_next;
  logic [cse_pkg::SIDX_W-1:0]     idx_next;
  logic [cse_pkg::PID_W-1:0]      wpid_next;
  logic [cse_pkg::CNT_W-1:0]      cnow_next;

  assign in_sem       = sem_index[cse_pkg::SEM_BITS-1:0];
  assign stat.req_nop = !(op == cse_pkg::OP_ALLOC || op == cse_pkg::OP_WAIT ||
                          op == cse_pkg::OP_POST);
  assign slot_raddr   = {in_sem, queue_heads[in_sem]};

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_op   <= cse_pkg::op_t'(op);
      req_sem  <= in_sem;
      req_init <= initial_count[cse_pkg::COUNT_BITS-1:0];
      req_pid  <= caller_pid[cse_pkg::PID_BITS-1:0];
    end
  end

  // waiter slot memory, head entry read on request latch
  always_ff @(posedge clk) begin
    if (slot_we) waiter_slots[slot_waddr] <= req_pid;
    if (cmd.latch) slot_rdata <= waiter_slots[slot_raddr];
  end

  // lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = cse_pkg::NUM_SEMS - 1; i >= 0; i--) begin
      if (owner_ids[i] == '0) begin
        free_found = 1'b1;
        free_idx   = cse_pkg::SEM_BITS'(i);
      end
    end
  end

  always_comb begin
    cnt       = pass_counts[req_sem];
    head      = queue_heads[req_sem];
    len       = queue_lengths[req_sem];
    tail      = head + len[cse_pkg::QPTR_BITS-1:0];
    tgt       = req_sem;
    tbl_we    = 1'b0;
    owner_we  = 1'b0;
    slot_we   = 1'b0;
    cnt_next  = cnt;
    head_next = head;
    len_next  = len;
    st_next   = cse_pkg::ST_ERROR;
    err_next  = cse_pkg::ERR_NONE;
    idx_next  = '0;
    wpid_next = '0;
    cnow_next = cnt;
    unique case (req_op)
      cse_pkg::OP_ALLOC: begin
        if (free_found) begin
          tgt       = free_idx;
          tbl_we    = 1'b1;
          owner_we  = 1'b1;
          cnt_next  = req_init;
          head_next = '0;
          len_next  = '0;
          st_next   = cse_pkg::ST_ALLOCATED;
          idx_next  = cse_pkg::SIDX_W'(free_idx);
          cnow_next = req_init;
        end else begin
          err_next  = cse_pkg::ERR_NO_FREE;
          cnow_next = '0;
        end
      end
      cse_pkg::OP_WAIT: begin
        if (cnt != '0) begin
          tbl_we    = 1'b1;
          cnt_next  = cnt - 1'b1;
          st_next   = cse_pkg::ST_PASSED;
          cnow_next = cnt - 1'b1;
        end else if (len >= cse_pkg::QLEN_FULL) begin
          err_next  = cse_pkg::ERR_QUEUE_FULL;
        end else begin
          tbl_we    = 1'b1;
          slot_we   = cmd.commit;
          len_next  = len + 1'b1;
          st_next   = cse_pkg::ST_BLOCKED;
        end
      end
      cse_pkg::OP_POST: begin
        tbl_we = 1'b1;
        if (len != '0) begin
          head_next = head + 1'b1;
          len_next  = len - 1'b1;
          st_next   = cse_pkg::ST_WOKE;
          wpid_next = cse_pkg::PID_W'(slot_rdata);
        end else begin
          if (cnt != cse_pkg::COUNT_MAX) cnt_next = cnt + 1'b1;
          st_next   = cse_pkg::ST_INCREMENTED;
          cnow_next = (cnt != cse_pkg::COUNT_MAX) ? cnt + 1'b1 : cnt;
        end
      end
      default: tbl_we = 1'b0;
    endcase
  end

  assign slot_waddr = {req_sem, tail};

  // semaphore tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cse_pkg::NUM_SEMS; i++) begin
        owner_ids[i]     <= '0;
        pass_counts[i]   <= '0;
        queue_heads[i]   <= '0;
        queue_lengths[i] <= '0;
      end
    end else if (cmd.commit && tbl_we) begin
      if (owner_we) owner_ids[tgt] <= req_pid;
      pass_counts[tgt]   <= cnt_next;
      queue_heads[tgt]   <= head_next;
      queue_lengths[tgt] <= len_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= st_next;
      error_kind    <= err_next;
      sem_index_out <= idx_next;
      woken_pid     <= wpid_next;
      count_now     <= cnow_next;
    end
  end

endmodule

FILE: rtl/cse_checker.sv
// Port-level checks for the counting semaphore engine, bound to the top
// level. Depends on cse_pkg and counting_semaphore_engine.
module cse_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [cse_pkg::OP_W-1:0]      op,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [cse_pkg::STATUS_W-1:0]  status,
  input logic [cse_pkg::ERR_W-1:0]     error_kind,
  input logic [cse_pkg::SIDX_W-1:0]    sem_index_out,
  input logic [cse_pkg::PID_W-1:0]     woken_pid,
  input logic [cse_pkg::CNT_W-1:0]     count_now
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(error_kind) && $stable(sem_index_out) && $stable(woken_pid) &&
      $stable(count_now))
    else $error("response changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((status == cse_pkg::ST_ERROR) == (error_kind != cse_pkg::ERR_NONE)))
    else $error("error kind does not match status");

  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != cse_pkg::ST_WOKE |-> woken_pid == '0)
    else $error("woken pid set without a wake");

  a_one_per_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (op == cse_pkg::OP_ALLOC || op == cse_pkg::OP_WAIT ||
      op == cse_pkg::OP_POST) |=> !(req_valid && req_ready))
    else $error("requests taken on consecutive cycles");

endmodule

bind counting_semaphore_engine cse_checker u_cse_checker (.*);

FILE: tb/counting_semaphore_engine_test.sv
`timescale 1ns / 100ps
// Self-checking bench for counting_semaphore_engine: a directed table, then random
// request streams, responses checked against typed rows or a table-level predictor.
// Depends on cse_pkg for widths, op, status and error codes.
module counting_semaphore_engine_test;
  import cse_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_UNTIL     = 1330;
  localparam int FILL_ALLOCS      = 20;
  localparam int PAUSE_AT         = 700;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES     = 10;
  localparam int PRINT_LIMIT      = 40;

  typedef struct packed {
    status_t             status;
    err_t                err;
    logic [SIDX_W-1:0]   idx;
    logic [PID_W-1:0]    pid;
    logic [CNT_W-1:0]    cnt;
  } sem_result_t;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [SIDX_W-1:0]   idx;
    logic [INIT_W-1:0]   init;
    logic [PID_W-1:0]    pid;
    int                  reps;
    bit                  typed;
    sem_result_t         want;
  } sem_row_t;

  typedef enum {MIX_OPS, FLOOD_QUEUE, CHURN_ONE} gen_mode_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  localparam sem_result_t NO_CHECK = '{ST_ERROR, ERR_NONE, 4'd0, 5'd0, 8'd0};

  sem_row_t dir_tbl [0:13] = '{
    '{OP_ALLOC,  4'd0,  8'd255, 5'd0,  1,  1'b1, '{ST_ALLOCATED, ERR_NONE, 4'd0, 5'd0, 8'd255}},
    '{OP_ALLOC,  4'd9,  8'd0,   5'd31, 1,  1'b1, '{ST_ALLOCATED, ERR_NONE, 4'd0, 5'd0, 8'd0}},
    '{OP_WAIT,   4'd0,  8'd170, 5'd1,  1,  1'b1, '{ST_BLOCKED, ERR_NONE, 4'd0, 5'd0, 8'd0}},
    '{OP_POST,   4'd0,  8'd85,  5'd2,  1,  1'b1, '{ST_WOKE, ERR_NONE, 4'd0, 5'd1, 8'd0}},
    '{OP_POST,   4'd0,  8'd0,   5'd0,  1,  1'b1, '{ST_INCREMENTED, ERR_NONE, 4'd0, 5'd0, 8'd1}},
    '{OP_WAIT,   4'd0,  8'd255, 5'd31, 1,  1'b1, '{ST_PASSED, ERR_NONE, 4'd0, 5'd0, 8'd0}},
    '{OP_UNUSED, 4'd15, 8'd255, 5'd31, 1,  1'b0, NO_CHECK},
    '{OP_ALLOC,  4'd15, 8'd254, 5'd1,  1,  1'b1, '{ST_ALLOCATED, ERR_NONE, 4'd1, 5'd0, 8'd254}},
    '{OP_POST,   4'd1,  8'd3,   5'd12, 1,  1'b0, NO_CHECK},
    '{OP_POST,   4'd1,  8'd128, 5'd21, 1,  1'b1, '{ST_INCREMENTED, ERR_NONE, 4'd0, 5'd0, 8'd255}},
    '{OP_WAIT,   4'd1,  8'd255, 5'd31, 1,  1'b0, NO_CHECK},
    '{OP_WAIT,   4'd15, 8'd66,  5'd30, 16, 1'b0, NO_CHECK},
    '{OP_WAIT,   4'd15, 8'd0,   5'd7,  1,  1'b1, '{ST_ERROR, ERR_QUEUE_FULL, 4'd0, 5'd0, 8'd0}},
    '{OP_POST,   4'd15, 8'd201, 5'd9,  16, 1'b0, NO_CHECK}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [ERR_W-1:0]     error_kind;
  logic [SIDX_W-1:0]    sem_index_out;
  logic [PID_W-1:0]     woken_pid;
  logic [CNT_W-1:0]     count_now;

  sem_row_t offer = '{OP_ALLOC, 4'd0, 8'd0, 5'd0, 1, 1'b0, NO_CHECK};

  logic [PID_BITS-1:0]   owner_tbl  [NUM_SEMS];
  logic [COUNT_BITS-1:0] pass_tbl   [NUM_SEMS];
  logic [QPTR_BITS-1:0]  head_tbl   [NUM_SEMS];
  logic [QLEN_BITS-1:0]  len_tbl    [NUM_SEMS];
  logic [PID_BITS-1:0]   waiter_tbl [SLOT_DEPTH];

  sem_result_t pending_results [$];
  sem_row_t    stim_q [$];
  int          reqs_taken = 0;
  int          rsps_seen = 0;
  int          mismatches = 0;
  int          status_hits [6];
  int          err_hits [3];

  counting_semaphore_engine dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .op            (offer.op),
    .sem_index     (offer.idx),
    .initial_count (offer.init),
    .caller_pid    (offer.pid),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .error_kind    (error_kind),
    .sem_index_out (sem_index_out),
    .woken_pid     (woken_pid),
    .count_now     (count_now)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH at %0t, response %0d, %s: got %0d want %0d",
               $realtime, rsps_seen, what, got, want);
  endtask

  function automatic bit semaphore_step(input logic [OP_W-1:0] opc,
                                        input logic [SIDX_W-1:0] sidx,
                                        input logic [INIT_W-1:0] init,
                                        input logic [PID_W-1:0] pid,
                                        output sem_result_t r);
    int  s;
    int  slot;
    bit  found;
    s = int'(sidx) % NUM_SEMS;
    found = 1'b0;
    r = NO_CHECK;
    semaphore_step = 1'b1;
    case (opc)
      OP_ALLOC: begin
        r = '{ST_ERROR, ERR_NO_FREE, 4'd0, 5'd0, 8'd0};
        for (int i = 0; i < NUM_SEMS; i++) begin
          if (!found && owner_tbl[i] == '0) begin
            found = 1'b1;
            owner_tbl[i] = PID_BITS'(pid);
            pass_tbl[i] = COUNT_BITS'(init);
            head_tbl[i] = '0;
            len_tbl[i] = '0;
            r = '{ST_ALLOCATED, ERR_NONE, SIDX_W'(i), 5'd0, CNT_W'(pass_tbl[i])};
          end
        end
      end
      OP_WAIT: begin
        if (pass_tbl[s] != '0) begin
          pass_tbl[s] = pass_tbl[s] - 1'b1;
          r = '{ST_PASSED, ERR_NONE, 4'd0, 5'd0, CNT_W'(pass_tbl[s])};
        end else if (len_tbl[s] >= QLEN_FULL) begin
          r = '{ST_ERROR, ERR_QUEUE_FULL, 4'd0, 5'd0, CNT_W'(pass_tbl[s])};
        end else begin
          slot = s * QUEUE_DEPTH + (int'(head_tbl[s]) + int'(len_tbl[s])) % QUEUE_DEPTH;
          waiter_tbl[slot] = PID_BITS'(pid);
          len_tbl[s] = len_tbl[s] + 1'b1;
          r = '{ST_BLOCKED, ERR_NONE, 4'd0, 5'd0, CNT_W'(pass_tbl[s])};
        end
      end
      OP_POST: begin
        if (len_tbl[s] != '0) begin
          slot = s * QUEUE_DEPTH + int'(head_tbl[s]);
          r = '{ST_WOKE, ERR_NONE, 4'd0, PID_W'(waiter_tbl[slot]), CNT_W'(pass_tbl[s])};
          head_tbl[s] = head_tbl[s] + 1'b1;
          len_tbl[s] = len_tbl[s] - 1'b1;
        end else begin
          if (pass_tbl[s] != COUNT_MAX) pass_tbl[s] = pass_tbl[s] + 1'b1;
          r = '{ST_INCREMENTED, ERR_NONE, 4'd0, 5'd0, CNT_W'(pass_tbl[s])};
        end
      end
      default: semaphore_step = 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    sem_result_t w;
    sem_result_t p;
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        owner_tbl[i] = '0;
        pass_tbl[i] = '0;
        head_tbl[i] = '0;
        len_tbl[i] = '0;
      end
    end else begin
      if (rsp_valid === 1'b1 && rsp_ready) begin
        rsps_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("response with nothing pending", int'(status), -1);
        end else begin
          w = pending_results.pop_front();
          if (status !== w.status) report_mismatch("status", int'(status), int'(w.status));
          if (error_kind !== w.err) report_mismatch("error_kind", int'(error_kind), int'(w.err));
          if (sem_index_out !== w.idx) report_mismatch("sem_index_out", int'(sem_index_out), int'(w.idx));
          if (woken_pid !== w.pid) report_mismatch("woken_pid", int'(woken_pid), int'(w.pid));
          if (count_now !== w.cnt) report_mismatch("count_now", int'(count_now), int'(w.cnt));
        end
      end
      if (req_valid && req_ready === 1'b1) begin
        reqs_taken++;
        if (semaphore_step(offer.op, offer.idx, offer.init, offer.pid, p)) begin
          status_hits[int'(p.status)]++;
          err_hits[int'(p.err)]++;
          pending_results.push_back(offer.typed ? offer.want : p);
        end
      end
    end
  end

  initial begin
    rx_mode_t rx_mode;
    int       stretch;
    bit       held;
    rx_mode = RX_OPEN;
    stretch = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && rsps_seen >= LONG_HOLD_AT) begin
        // hold off long enough that the engine backs up into the request side
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          stretch = $urandom_range(10, 60);
        end
        stretch--;
        case (rx_mode)
          RX_OPEN:   rsp_ready <= 1'b1;
          RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d requests taken, %0d responses still pending",
             reqs_taken, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    sem_row_t  it;
    gen_mode_t mode;
    int        run;
    int        pick;
    int        flood_waits;
    int        burst_left;
    int        gap;
    int        target;
    logic [SIDX_W-1:0] focus;

    foreach (dir_tbl[r]) begin
      for (int k = 0; k < dir_tbl[r].reps; k++) begin
        it = dir_tbl[r];
        it.pid = dir_tbl[r].pid ^ PID_W'(k);
        stim_q.push_back(it);
      end
    end

    while (stim_q.size() < RANDOM_UNTIL) begin
      mode = gen_mode_t'($urandom_range(0, 2));
      run = (mode == FLOOD_QUEUE) ? 48 : $urandom_range(8, 40);
      flood_waits = $urandom_range(14, 24);
      focus = SIDX_W'($urandom_range(0, 15));
      for (int j = 0; j < run; j++) begin
        it.idx = SIDX_W'($urandom_range(0, 15));
        it.init = INIT_W'($urandom_range(0, 255));
        it.pid = PID_W'($urandom_range(0, 31));
        it.reps = 1;
        it.typed = 1'b0;
        it.want = NO_CHECK;
        if ($urandom_range(0, 4) == 0) it.init = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        pick = $urandom_range(0, 99);
        case (mode)
          FLOOD_QUEUE: begin
            it.idx = focus;
            it.op = (j < flood_waits) ? OP_WAIT : OP_POST;
            if (pick < 4) it.op = OP_UNUSED;
          end
          CHURN_ONE: begin
            it.idx = focus;
            it.op = (pick < 50) ? OP_WAIT : (pick < 96) ? OP_POST : OP_ALLOC;
          end
          default: begin
            it.op = (pick < 15) ? OP_ALLOC : (pick < 55) ? OP_WAIT :
                    (pick < 95) ? OP_POST : OP_UNUSED;
          end
        endcase
        if (it.op == OP_ALLOC && $urandom_range(0, 7) != 0) it.pid = '0;
        stim_q.push_back(it);
      end
    end

    // claim every entry so the table runs out of free semaphores
    for (int j = 0; j < FILL_ALLOCS; j++) begin
      it.op = OP_ALLOC;
      it.idx = SIDX_W'($urandom_range(0, 15));
      it.init = INIT_W'($urandom_range(0, 255));
      it.pid = PID_W'($urandom_range(1, 31));
      it.reps = 1;
      it.typed = 1'b0;
      it.want = NO_CHECK;
      stim_q.push_back(it);
    end

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    burst_left = 0;
    for (int k = 0; k < stim_q.size(); k++) begin
      if (k == PAUSE_AT) begin
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      offer <= stim_q[k];
      req_valid <= 1'b1;
      target = reqs_taken + 1;
      do @(negedge clk); while (reqs_taken < target);
    end
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d responses: %0d allocated, %0d passed, %0d blocked,",
             reqs_taken, rsps_seen, status_hits[ST_ALLOCATED], status_hits[ST_PASSED],
             status_hits[ST_BLOCKED]);
    $display("  %0d woken, %0d incremented, %0d no-free and %0d queue-full errors",
             status_hits[ST_WOKE], status_hits[ST_INCREMENTED], err_hits[ERR_NO_FREE],
             err_hits[ERR_QUEUE_FULL]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
